### sv/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/tfwc_pkg.sv
`timescale 1ns / 1ps

package tfwc_pkg;

    localparam int WINDOW_DEF = 4;
    localparam int SMP_W      = 16;
    localparam int TH_W       = 15;
    localparam int WAVE_W     = 3;
    localparam int FREQ_W     = 15;

    localparam logic [TH_W-1:0] TILT_RST  = 15'd600;
    localparam logic [TH_W-1:0] LEVEL_RST = 15'd200;

    localparam logic [WAVE_W-1:0] WAVE_MIN = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_MAX = 3'd5;

    localparam logic [FREQ_W-1:0] FREQ_RST  = 15'd100;
    localparam logic [FREQ_W:0]   FREQ_MAX  = 16'd32767;
    localparam logic [FREQ_W:0]   FREQ_1000 = 16'd1000;
    localparam logic [FREQ_W:0]   FREQ_100  = 16'd100;
    localparam logic [FREQ_W:0]   FREQ_10   = 16'd10;
    localparam logic [FREQ_W:0]   FREQ_1    = 16'd1;

    localparam logic REG_TILT  = 1'b0;
    localparam logic REG_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        ZONE_NONE  = 2'd0,
        ZONE_POS   = 2'd1,
        ZONE_NEG   = 2'd2,
        ZONE_LEVEL = 2'd3
    } t_zone;

    typedef struct packed {
        logic                    axis_sel;
        logic signed [SMP_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic                    out_axis;
        logic signed [SMP_W-1:0] filtered_value;
        logic [1:0]              zone_code;
        logic [WAVE_W-1:0]       wave_select;
        logic [FREQ_W-1:0]       frequency_setting;
    } t_out_item;

endpackage

### sv/tfwc_ram.sv
`timescale 1ns / 1ps

module tfwc_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tilt_filter_wave_control.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tilt filter and wave control. Each input transaction carries one signed sample for the x or
// y axis; it is written into that axis' window of WINDOW entries, held in a small RAM, and the
// block returns one output transaction with the trimmed mean of the window (sum less minimum and
// maximum, divided by WINDOW-2, truncated toward zero), the axis zone after hysteresis, and the
// wave and frequency settings after any step that a zone change causes. The window is read back
// through the single RAM read port one entry per cycle, followed by a reciprocal divide in the
// trim, multiply and correct steps and then the zone update; the next item is accepted only
// after that. A finished result waits in an output register, so the next sample is accepted
// while it is still stalled. Both windows read as zero after reset through per-entry valid
// flags; there is no clearing pass. The thresholds are written through the APB port at byte
// addresses 0 and 4 while the block is idle; the user must ensure this, it is not enforced.
module tilt_filter_wave_control #(
    parameter int WINDOW = tfwc_pkg::WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tfwc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tfwc_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SMP_W  = tfwc_pkg::SMP_W;
    localparam int DEPTH  = 2 * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int ACC_W  = SMP_W + 1 + $clog2(WINDOW);
    localparam int MAG_W  = SMP_W + $clog2(WINDOW - 2);
    localparam int K      = MAG_W;
    localparam int RCP_W  = K + 1;
    localparam int PROD_W = MAG_W + RCP_W;
    localparam int Q_W    = PROD_W - K;

    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << K) / (WINDOW - 2));
    localparam logic [Q_W-1:0]   DIVC  = Q_W'(WINDOW - 2);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_LAST = 7'b0000100,
        S_TRIM = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_CORR = 7'b0100000,
        S_ZONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [tfwc_pkg::TH_W-1:0] r_tilt, r_level;
    logic [IDX_W-1:0]          r_pos [2];
    logic [DEPTH-1:0]          r_vld;
    tfwc_pkg::t_zone           r_zone [2];
    logic [tfwc_pkg::WAVE_W-1:0] r_wave;
    logic [tfwc_pkg::FREQ_W-1:0] r_freq;

    logic                    r_axis;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_rd_vld, r_first, r_rd_ok;
    logic signed [ACC_W-1:0] r_sum, r_min, r_max;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_prod;
    logic signed [SMP_W-1:0] r_filt;

    logic                r_out_valid;
    tfwc_pkg::t_out_item r_out_data;

    logic              in_acc, out_free, out_load, wave_bad;
    logic [ADDR_W-1:0] waddr, raddr, rbase;
    logic [SMP_W-1:0]  rdata;
    logic signed [ACC_W-1:0] rd_val, trim;
    logic [Q_W-1:0]    q_est, q_fix, qd, rem;
    tfwc_pkg::t_zone   zone_prev, nz;
    logic signed [SMP_W:0] filt_e, tilt_e, level_e;
    logic [tfwc_pkg::WAVE_W-1:0] n_wave;
    logic [tfwc_pkg::FREQ_W:0]   f_cur, f_new;
    logic [tfwc_pkg::FREQ_W-1:0] n_freq;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_ZONE) && out_free;
    assign wave_bad   = (r_wave < tfwc_pkg::WAVE_MIN) || (r_wave > tfwc_pkg::WAVE_MAX);

    assign waddr = (i_in_data.axis_sel ? ADDR_W'(WINDOW) : '0)
                   + ADDR_W'(r_pos[i_in_data.axis_sel]);
    assign rbase = r_axis ? ADDR_W'(WINDOW) : '0;
    assign raddr = rbase + ADDR_W'(r_idx);

    tfwc_ram #(
        .DATA_W (SMP_W),
        .DEPTH  (DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (waddr),
        .i_wdata (i_in_data.sample_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_READ;
            S_READ: if (r_idx == IDX_LAST) n_state = S_LAST;
            S_LAST: n_state = S_TRIM;
            S_TRIM: n_state = S_MUL;
            S_MUL:  n_state = S_CORR;
            S_CORR: n_state = S_ZONE;
            S_ZONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_val = r_rd_ok ? ACC_W'($signed(rdata)) : '0;
        trim   = r_sum - r_min - r_max;
        q_est  = r_prod[PROD_W-1:K];
        qd     = Q_W'(q_est * DIVC);
        rem    = Q_W'(r_mag) - qd;
        q_fix  = (rem >= DIVC) ? q_est + Q_W'(1) : q_est;
    end

    always_comb begin
        zone_prev = r_zone[r_axis];
        filt_e    = (SMP_W + 1)'(r_filt);
        tilt_e    = $signed({2'b00, r_tilt});
        level_e   = $signed({2'b00, r_level});
        if (filt_e > tilt_e) begin
            nz = tfwc_pkg::ZONE_POS;
        end else if (filt_e < -tilt_e) begin
            nz = tfwc_pkg::ZONE_NEG;
        end else if (filt_e > -level_e && filt_e < level_e) begin
            nz = tfwc_pkg::ZONE_LEVEL;
        end else begin
            nz = zone_prev;
        end

        n_wave = r_wave;
        f_cur  = {1'b0, r_freq};
        f_new  = f_cur;
        if (nz != zone_prev) begin
            if (!r_axis) begin
                if (nz == tfwc_pkg::ZONE_POS && r_wave < tfwc_pkg::WAVE_MAX) begin
                    n_wave = r_wave + 3'd1;
                end else if (nz == tfwc_pkg::ZONE_NEG && r_wave > tfwc_pkg::WAVE_MIN) begin
                    n_wave = r_wave - 3'd1;
                end
            end else if (nz == tfwc_pkg::ZONE_POS) begin
                if (f_cur > tfwc_pkg::FREQ_1000) begin
                    f_new = f_cur + tfwc_pkg::FREQ_1000;
                end else if (f_cur >= tfwc_pkg::FREQ_100) begin
                    f_new = f_cur + tfwc_pkg::FREQ_100;
                end else if (f_cur >= tfwc_pkg::FREQ_10) begin
                    f_new = f_cur + tfwc_pkg::FREQ_10;
                end else if (f_cur >= tfwc_pkg::FREQ_1) begin
                    f_new = f_cur + tfwc_pkg::FREQ_1;
                end
                if (f_new > tfwc_pkg::FREQ_MAX) begin
                    f_new = tfwc_pkg::FREQ_MAX;
                end
                if (f_new < tfwc_pkg::FREQ_1) begin
                    f_new = tfwc_pkg::FREQ_1;
                end
            end else if (nz == tfwc_pkg::ZONE_NEG) begin
                if (f_cur > tfwc_pkg::FREQ_1000) begin
                    f_new = f_cur - tfwc_pkg::FREQ_1000;
                end else if (f_cur > tfwc_pkg::FREQ_100) begin
                    f_new = f_cur - tfwc_pkg::FREQ_100;
                end else if (f_cur > tfwc_pkg::FREQ_10) begin
                    f_new = f_cur - tfwc_pkg::FREQ_10;
                end else if (f_cur > tfwc_pkg::FREQ_1) begin
                    f_new = f_cur - tfwc_pkg::FREQ_1;
                end else begin
                    f_new = tfwc_pkg::FREQ_1;
                end
            end
        end
        n_freq = f_new[tfwc_pkg::FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tilt      <= tfwc_pkg::TILT_RST;
            r_level     <= tfwc_pkg::LEVEL_RST;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_vld       <= '0;
            r_zone[0]   <= tfwc_pkg::ZONE_NONE;
            r_zone[1]   <= tfwc_pkg::ZONE_NONE;
            r_wave      <= tfwc_pkg::WAVE_MIN;
            r_freq      <= tfwc_pkg::FREQ_RST;
            r_rd_vld    <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_READ);
            r_first  <= (r_state == S_READ) && (r_idx == '0);

            if (psel && penable && pwrite) begin
                case (paddr[2])
                    tfwc_pkg::REG_TILT:  r_tilt  <= pwdata[tfwc_pkg::TH_W-1:0];
                    tfwc_pkg::REG_LEVEL: r_level <= pwdata[tfwc_pkg::TH_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_vld[waddr] <= 1'b1;
                r_pos[i_in_data.axis_sel] <= (r_pos[i_in_data.axis_sel] == IDX_LAST)
                    ? '0 : r_pos[i_in_data.axis_sel] + IDX_W'(1);
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_zone[r_axis] <= nz;
                r_wave         <= n_wave;
                r_freq         <= n_freq;
                r_out_valid    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_axis <= i_in_data.axis_sel;
            r_idx  <= '0;
        end else if (r_state == S_READ) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_rd_ok <= r_vld[raddr];

        if (r_rd_vld) begin
            if (r_first) begin
                r_sum <= rd_val;
                r_min <= rd_val;
                r_max <= rd_val;
            end else begin
                r_sum <= r_sum + rd_val;
                if (rd_val < r_min) r_min <= rd_val;
                if (rd_val > r_max) r_max <= rd_val;
            end
        end

        if (r_state == S_TRIM) begin
            r_neg <= trim[ACC_W-1];
            r_mag <= trim[ACC_W-1] ? MAG_W'(-trim) : MAG_W'(trim);
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP);
        end
        if (r_state == S_CORR) begin
            r_filt <= r_neg ? SMP_W'(-q_fix) : SMP_W'(q_fix);
        end

        if (out_load) begin
            r_out_data.out_axis          <= r_axis;
            r_out_data.filtered_value    <= r_filt;
            r_out_data.zone_code         <= nz;
            r_out_data.wave_select       <= n_wave;
            r_out_data.frequency_setting <= n_freq;
        end
    end

    always_comb begin
        case (paddr[2])
            tfwc_pkg::REG_TILT:  prdata = {17'd0, r_tilt};
            tfwc_pkg::REG_LEVEL: prdata = {17'd0, r_level};
            default:             prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_CLK(a_accept_blocks, i_clk, i_rst_n, in_acc |=> o_in_stall, "accept while busy")
    `ASSERT_CLK(a_zone_delivers, i_clk, i_rst_n, out_load |=> r_out_valid, "result lost")
    `ASSERT_NEVER(a_set_range, i_clk, i_rst_n, r_freq == '0 || wave_bad, "setting out of range")

endmodule

### tb/tilt_filter_wave_control_check.sv
`timescale 1ns / 1ps

module tilt_filter_wave_control_check
    import tfwc_pkg::*;
#(
    parameter int WIN = WINDOW_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  t_in_item  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  t_out_item out_data,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    input  logic      pready,
    output int        mismatch_count,
    output int        pending_count
);

    logic [TH_W-1:0]         tilt_cfg;
    logic [TH_W-1:0]         level_cfg;
    logic signed [SMP_W-1:0] window_mem [2][WIN];
    int                      wr_pos [2];
    t_zone                   zone_st [2];
    logic [WAVE_W-1:0]       wave_st;
    int                      freq_st;
    t_out_item               readings_due [$];
    int                      result_idx;

    function automatic int freq_raise(input int f);
        int g;
        g = f;
        if (g > int'(FREQ_1000)) g = g + int'(FREQ_1000);
        else if (g >= int'(FREQ_100)) g = g + int'(FREQ_100);
        else if (g >= int'(FREQ_10)) g = g + int'(FREQ_10);
        else if (g >= int'(FREQ_1)) g = g + int'(FREQ_1);
        if (g > int'(FREQ_MAX)) g = int'(FREQ_MAX);
        if (g < int'(FREQ_1)) g = int'(FREQ_1);
        return g;
    endfunction

    function automatic int freq_lower(input int f);
        int g;
        g = f;
        if (g > int'(FREQ_1000)) g = g - int'(FREQ_1000);
        else if (g > int'(FREQ_100)) g = g - int'(FREQ_100);
        else if (g > int'(FREQ_10)) g = g - int'(FREQ_10);
        else if (g > int'(FREQ_1)) g = g - int'(FREQ_1);
        else g = int'(FREQ_1);
        return g;
    endfunction

    function automatic t_out_item next_reading(input t_in_item it);
        t_out_item r;
        int        ax;
        int        k;
        int        v;
        int        sum;
        int        lo;
        int        hi;
        int        filt;
        int        tilt;
        int        level;
        t_zone     nz;
        ax = int'(it.axis_sel);
        window_mem[ax][wr_pos[ax]] = it.sample_value;
        wr_pos[ax] = (wr_pos[ax] + 1 >= WIN) ? 0 : wr_pos[ax] + 1;
        lo = int'(window_mem[ax][0]);
        hi = lo;
        sum = 0;
        for (k = 0; k < WIN; k++) begin
            v = int'(window_mem[ax][k]);
            if (v > hi) hi = v;
            if (v < lo) lo = v;
            sum = sum + v;
        end
        filt = (sum - lo - hi) / (WIN - 2);
        tilt = int'(tilt_cfg);
        level = int'(level_cfg);
        if (filt > tilt) nz = ZONE_POS;
        else if (filt < -tilt) nz = ZONE_NEG;
        else if (filt > -level && filt < level) nz = ZONE_LEVEL;
        else nz = zone_st[ax];
        if (nz != zone_st[ax]) begin
            zone_st[ax] = nz;
            if (ax == 0) begin
                if (nz == ZONE_POS) begin
                    wave_st = (wave_st >= WAVE_MAX) ? WAVE_MAX : wave_st + 1'b1;
                end else if (nz == ZONE_NEG) begin
                    wave_st = (wave_st <= WAVE_MIN) ? WAVE_MIN : wave_st - 1'b1;
                end
            end else begin
                if (nz == ZONE_POS) freq_st = freq_raise(freq_st);
                else if (nz == ZONE_NEG) freq_st = freq_lower(freq_st);
            end
        end
        r.out_axis          = it.axis_sel;
        r.filtered_value    = filt[SMP_W-1:0];
        r.zone_code         = zone_st[ax];
        r.wave_select       = wave_st;
        r.frequency_setting = freq_st[FREQ_W-1:0];
        return r;
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            tilt_cfg  = TILT_RST;
            level_cfg = LEVEL_RST;
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < WIN; k++) window_mem[a][k] = '0;
                wr_pos[a]  = 0;
                zone_st[a] = ZONE_NONE;
            end
            wave_st = WAVE_MIN;
            freq_st = int'(FREQ_RST);
            readings_due.delete();
            result_idx = 0;
            mismatch_count = 0;
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                if (paddr[2] == REG_TILT) tilt_cfg = pwdata[TH_W-1:0];
                else level_cfg = pwdata[TH_W-1:0];
            end
            if (out_valid && !out_stall) begin
                if (readings_due.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("check: result %0d arrived with nothing expected", result_idx);
                    end
                    mismatch_count++;
                end else begin
                    want = readings_due.pop_front();
                    if (out_data.out_axis !== want.out_axis
                            || out_data.filtered_value !== want.filtered_value
                            || out_data.zone_code !== want.zone_code
                            || out_data.wave_select !== want.wave_select
                            || out_data.frequency_setting !== want.frequency_setting) begin
                        if (mismatch_count < 10) begin
                            $display("check: #%0d exp ax %0d filt %0d zone %0d wave %0d freq %0d",
                                     result_idx, want.out_axis, want.filtered_value,
                                     want.zone_code, want.wave_select, want.frequency_setting);
                            $display("check: #%0d got ax %0d filt %0d zone %0d wave %0d freq %0d",
                                     result_idx, out_data.out_axis, out_data.filtered_value,
                                     out_data.zone_code, out_data.wave_select,
                                     out_data.frequency_setting);
                        end
                        mismatch_count++;
                    end
                end
                result_idx++;
            end
            if (in_valid && !in_stall) readings_due.push_back(next_reading(in_data));
            pending_count = readings_due.size();
        end
    end

endmodule

### tb/tilt_filter_wave_control_tb.sv
`timescale 1ns / 1ps

module tilt_filter_wave_control_tb;
    import tfwc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 2 * (WINDOW_DEF + 6) + 4;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 8;
    localparam int DIR_N       = 25;

    localparam logic [2:0] ADDR_TILT  = {REG_TILT, 2'b00};
    localparam logic [2:0] ADDR_LEVEL = {REG_LEVEL, 2'b00};

    typedef enum int {
        K_CALM, K_POS, K_NEG, K_NEAR_TILT, K_NEAR_LEVEL, K_ANY
    } t_kind;

    typedef enum int {
        BIAS_MIX, BIAS_UP, BIAS_DOWN
    } t_bias;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       psel      = 1'b0;
    logic       penable   = 1'b0;
    logic       pwrite    = 1'b0;
    logic [2:0] paddr     = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic       pready;

    int mismatch_count;
    int pending_count;
    int cycle_count;
    int hold_requests = 0;
    int cur_tilt  = int'(TILT_RST);
    int cur_level = int'(LEVEL_RST);
    bit swing_out [2] = '{1'b1, 1'b1};

    logic dir_axis [DIR_N] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    int   dir_val  [DIR_N] = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0,
                               601, 601, 601, 600, 600, -3,
                               32767, 32767, 32767, 199, 199, 199, -601, -601, -601, -1};

    int    phase_tilt  [NUM_PHASES] = '{600, 600, 0, 32767, 300, 32767, 0, 600};
    int    phase_level [NUM_PHASES] = '{200, 200, 0, 32767, 2000, 0, 32767, 200};
    t_bias phase_bias  [NUM_PHASES] = '{BIAS_UP, BIAS_DOWN, BIAS_MIX, BIAS_MIX,
                                        BIAS_MIX, BIAS_MIX, BIAS_MIX, BIAS_MIX};
    int    phase_items [NUM_PHASES] = '{500, 600, 100, 100, 100, 100, 80, 100};

    always #2 clk = ~clk;

    tilt_filter_wave_control dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tilt_filter_wave_control_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic logic signed [SMP_W-1:0] pick_sample(input t_kind kind);
        int v;
        int lo;
        case (kind)
            K_CALM: v = int'($urandom_range(80, 0)) - 40;
            K_POS: begin
                lo = (cur_tilt < 32767) ? cur_tilt + 1 : 32767;
                v = int'($urandom_range(32767, lo));
            end
            K_NEG: v = -int'($urandom_range(32768, cur_tilt + 1));
            K_NEAR_TILT: begin
                v = cur_tilt + int'($urandom_range(4, 0)) - 2;
                if ($urandom_range(1, 0) == 1) v = -v;
            end
            K_NEAR_LEVEL: begin
                v = cur_level + int'($urandom_range(4, 0)) - 2;
                if ($urandom_range(1, 0) == 1) v = -v;
            end
            default: v = int'($urandom_range(65535, 0)) - 32768;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SMP_W-1:0];
    endfunction

    task automatic send_sample(input logic ax, input logic signed [SMP_W-1:0] value);
        in_valid <= 1'b1;
        in_data  <= '{axis_sel: ax, sample_value: value};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_thresholds(input int tilt, input int level);
        cur_tilt  = tilt;
        cur_level = level;
        apb_write(ADDR_TILT, ($urandom() & 32'hFFFF_8000) | 32'(tilt));
        apb_write(ADDR_LEVEL, ($urandom() & 32'hFFFF_8000) | 32'(level));
    endtask

    task automatic run_phase(input t_bias bias, input int n_items);
        int    sent;
        int    run_len;
        int    burst_left;
        int    k;
        logic  ax;
        t_kind kind;
        sent = 0;
        burst_left = $urandom_range(24, 1);
        while (sent < n_items) begin
            if (bias == BIAS_MIX) ax = 1'($urandom_range(1, 0));
            else ax = ($urandom_range(9, 0) < 7);
            if ($urandom_range(9, 0) == 0) begin
                kind = K_ANY;
                run_len = 1;
            end else if (bias == BIAS_MIX) begin
                kind = t_kind'($urandom_range(5, 0));
                run_len = $urandom_range(5, 1);
            end else begin
                if (swing_out[ax]) kind = (bias == BIAS_UP) ? K_POS : K_NEG;
                else kind = K_CALM;
                swing_out[ax] = !swing_out[ax];
                run_len = $urandom_range(4, 3);
            end
            for (k = 0; k < run_len; k++) begin
                send_sample(ax, pick_sample(kind));
                sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(3, 0) == 0) pause_sender($urandom_range(30, 8));
                    else pause_sender($urandom_range(5, 0));
                    burst_left = $urandom_range(24, 1);
                end
            end
            if ($urandom_range(149, 0) == 0) drain_results();
        end
    endtask

    initial begin
        int i;
        int ph;
        int tilt;
        int level;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (i = 0; i < DIR_N; i++) begin
            send_sample(dir_axis[i], dir_val[i][SMP_W-1:0]);
        end
        drain_results();
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            tilt  = phase_tilt[ph];
            level = phase_level[ph];
            if (ph == NUM_PHASES - 1) begin
                tilt  = $urandom_range(4000, 0);
                level = $urandom_range(tilt + 500, 0);
            end
            set_thresholds(tilt, level);
            if (ph == 0) hold_requests++;
            run_phase(phase_bias[ph], phase_items[ph]);
            drain_results();
        end
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        int holds_served;
        int hold_left;
        int seg_left;
        int seg_mode;
        holds_served = 0;
        hold_left = 0;
        seg_left = 0;
        seg_mode = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(60, 1);
                    seg_mode = $urandom_range(3, 0);
                end
                seg_left--;
                case (seg_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(3, 0) == 0);
                    2: out_stall <= 1'($urandom_range(1, 0));
                    default: out_stall <= ($urandom_range(3, 0) != 0);
                endcase
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
